### hdl/segment_plane_intersect_top_defines.svh
// ---------------------------------------------------------------------------
// Segment/plane intersection: assertion macros
// Shared property shorthands for the assertions of the top level.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PLANE_INTERSECT_TOP_DEFINES_SVH
`define SEGMENT_PLANE_INTERSECT_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SPI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition never holds.
`define SPI_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### hdl/spi_pkg.sv
// ---------------------------------------------------------------------------
// Segment/plane intersection: package
// Widths, register indexes and relation codes shared by all modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

	localparam int COORD_W = 32;                 // Q16.16 coordinate
	localparam int DIFF_W  = COORD_W + 1;        // difference of two coordinates
	localparam int PROD_W  = COORD_W + DIFF_W;   // one dot product term
	localparam int DOT_W   = PROD_W + 2;         // sum of three terms
	localparam int MAG_W   = DOT_W - 1;          // magnitude of a dot product
	localparam int NUM_W   = MAG_W + DIFF_W;     // |num| * |b - a|
	localparam int QUO_W   = 35;                 // quotient bits of a hit offset
	localparam int REM_W   = MAG_W + 1;          // partial remainder
	localparam int DTOL_W  = 32;
	localparam int PTOL_W  = 16;
	localparam int TT_W    = MAG_W + PTOL_W;     // den * param_tolerance
	localparam int PFRAC   = 30;                 // fraction bits of t tolerance
	localparam int CMP_W   = DOT_W + PFRAC + 3;  // classification compare width
	localparam int CHUNK_W = 22;                 // split of |num| for products
	localparam int DEN_LO_W = 33;                // split of den for tolerance product
	localparam int SUM_W   = QUO_W + 2;          // start + offset before saturation

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_DOT_TOL   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARAM_TOL = 8'd1;

	localparam logic [1:0] REL_NONE  = 2'd0;
	localparam logic [1:0] REL_HIT   = 2'd1;
	localparam logic [1:0] REL_TOUCH = 2'd2;
	localparam logic [1:0] REL_CONT  = 2'd3;

	localparam int TAG_W = COORD_W + 1;          // {neg, start}

	typedef logic [2:0][COORD_W-1:0] vec3_t;
	typedef logic [2:0][DIFF_W-1:0]  dvec3_t;
	typedef logic [2:0][NUM_W-1:0]   nvec3_t;

endpackage

`default_nettype wire

### hdl/spi_dot.sv
// ---------------------------------------------------------------------------
// Segment/plane intersection: dot products
// Three stages: differences, products, sums of num = n.(p-a), den = n.(b-a).
// ---------------------------------------------------------------------------
`default_nettype none

module spi_dot
	import spi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  vec3_t                   in_pt,
	input  vec3_t                   in_nrm,
	input  vec3_t                   in_sa,
	input  vec3_t                   in_sb,
	output logic                    out_valid,
	output logic signed [DOT_W-1:0] out_num,
	output logic signed [DOT_W-1:0] out_den,
	output vec3_t                   out_sa,
	output dvec3_t                  out_sd
);

	logic vld_s1, vld_s2, vld_s3;
	vec3_t  nrm_s1, sa_s1, sa_s2, sa_s3;
	dvec3_t dpa_s1, dba_s1, dba_s2, dba_s3;
	logic signed [PROD_W-1:0] pa_s2 [3];
	logic signed [PROD_W-1:0] ba_s2 [3];
	logic signed [DOT_W-1:0] num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dpa_s1[i] <= {in_pt[i][COORD_W-1], in_pt[i]} - {in_sa[i][COORD_W-1], in_sa[i]};
				dba_s1[i] <= {in_sb[i][COORD_W-1], in_sb[i]} - {in_sa[i][COORD_W-1], in_sa[i]};
				pa_s2[i]  <= PROD_W'($signed(nrm_s1[i]) * $signed(dpa_s1[i]));
				ba_s2[i]  <= PROD_W'($signed(nrm_s1[i]) * $signed(dba_s1[i]));
			end
			nrm_s1 <= in_nrm;
			sa_s1  <= in_sa;
			sa_s2  <= sa_s1;
			dba_s2 <= dba_s1;
			num_s3 <= DOT_W'(pa_s2[0]) + DOT_W'(pa_s2[1]) + DOT_W'(pa_s2[2]);
			den_s3 <= DOT_W'(ba_s2[0]) + DOT_W'(ba_s2[1]) + DOT_W'(ba_s2[2]);
			sa_s3  <= sa_s2;
			dba_s3 <= dba_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_num   = num_s3;
	assign out_den   = den_s3;
	assign out_sa    = sa_s3;
	assign out_sd    = dba_s3;

endmodule

`default_nettype wire

### hdl/spi_prep.sv
// ---------------------------------------------------------------------------
// Segment/plane intersection: classification and dividend build
// Four stages: sign normalize, partial products, combine, classify.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_prep
	import spi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [DTOL_W-1:0]       dot_tol,
	input  logic [PTOL_W-1:0]       param_tol,
	input  logic                    in_valid,
	input  logic signed [DOT_W-1:0] in_num,
	input  logic signed [DOT_W-1:0] in_den,
	input  vec3_t                   in_sa,
	input  dvec3_t                  in_sd,
	output logic                    out_valid,
	output logic [1:0]              out_rel,
	output nvec3_t                  out_dvd,
	output logic [MAG_W-1:0]        out_den,
	output vec3_t                   out_sa,
	output logic [2:0]              out_neg
);

	logic vld_s4, vld_s5, vld_s6, vld_s7;

	// stage 4
	logic signed [DOT_W-1:0] numn_s4, numn_s5, numn_s6;
	logic [MAG_W-1:0] denp_s4, denp_s5, denp_s6, denp_s7;
	logic par_s4, par_s5, par_s6, nz_s4, nz_s5, nz_s6;
	vec3_t sa_s4, sa_s5, sa_s6, sa_s7;
	dvec3_t smag_s4;
	logic [2:0] ssg_s4, neg_s5, neg_s6, neg_s7;

	// stage 5/6
	logic [CHUNK_W+DIFF_W-1:0] pp_s5 [3][3];
	logic [DEN_LO_W+PTOL_W-1:0] tl_s5, th_s5;
	nvec3_t dvd_s6, dvd_s7;
	logic [TT_W-1:0] tt_s6;
	logic [1:0] rel_s7;

	logic [DOT_W-1:0] abs_num, abs_den, abs_nn;
	logic signed [DOT_W-1:0] numn;
	logic signed [CMP_W-1:0] big, d30, tts;
	logic none_c, touch_c;
	logic [1:0] rel_c;

	always_comb begin
		abs_num = in_num[DOT_W-1] ? DOT_W'(-in_num) : DOT_W'(in_num);
		abs_den = in_den[DOT_W-1] ? DOT_W'(-in_den) : DOT_W'(in_den);
		numn    = in_den[DOT_W-1] ? -in_num : in_num;
		abs_nn  = numn_s4[DOT_W-1] ? DOT_W'(-numn_s4) : DOT_W'(numn_s4);
	end

	always_comb begin
		big = CMP_W'(numn_s6) <<< PFRAC;
		d30 = $signed(CMP_W'(denp_s6)) <<< PFRAC;
		tts = $signed(CMP_W'(tt_s6));
		none_c  = (big > d30 + tts) || (big < -tts);
		touch_c = (big <= tts) || (big - d30 >= -tts);
		priority if (par_s6) begin
			rel_c = nz_s6 ? REL_CONT : REL_NONE;
		end else if (none_c) begin
			rel_c = REL_NONE;
		end else if (touch_c) begin
			rel_c = REL_TOUCH;
		end else begin
			rel_c = REL_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// normalize so that den is positive
			numn_s4 <= numn;
			denp_s4 <= abs_den[MAG_W-1:0];
			par_s4  <= abs_den <= DOT_W'(dot_tol);
			nz_s4   <= abs_num <= DOT_W'(dot_tol);
			sa_s4   <= in_sa;
			for (int i = 0; i < 3; i++) begin
				ssg_s4[i]  <= in_sd[i][DIFF_W-1];
				smag_s4[i] <= in_sd[i][DIFF_W-1] ? DIFF_W'(-in_sd[i]) : in_sd[i];
			end
			// partial products
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s5[i][j] <= abs_nn[j*CHUNK_W +: CHUNK_W] * smag_s4[i];
				end
				neg_s5[i] <= ssg_s4[i] ^ numn_s4[DOT_W-1];
			end
			tl_s5   <= denp_s4[DEN_LO_W-1:0] * param_tol;
			th_s5   <= denp_s4[MAG_W-1:DEN_LO_W] * param_tol;
			numn_s5 <= numn_s4;
			denp_s5 <= denp_s4;
			par_s5  <= par_s4;
			nz_s5   <= nz_s4;
			sa_s5   <= sa_s4;
			// combine
			for (int i = 0; i < 3; i++) begin
				dvd_s6[i] <= NUM_W'(pp_s5[i][0]) + (NUM_W'(pp_s5[i][1]) << CHUNK_W)
					+ (NUM_W'(pp_s5[i][2]) << (2 * CHUNK_W));
			end
			tt_s6   <= TT_W'(tl_s5) + (TT_W'(th_s5) << DEN_LO_W);
			numn_s6 <= numn_s5;
			denp_s6 <= denp_s5;
			par_s6  <= par_s5;
			nz_s6   <= nz_s5;
			sa_s6   <= sa_s5;
			neg_s6  <= neg_s5;
			// classify
			rel_s7  <= rel_c;
			dvd_s7  <= dvd_s6;
			denp_s7 <= denp_s6;
			sa_s7   <= sa_s6;
			neg_s7  <= neg_s6;
		end
	end

	assign out_valid = vld_s7;
	assign out_rel   = rel_s7;
	assign out_dvd   = dvd_s7;
	assign out_den   = denp_s7;
	assign out_sa    = sa_s7;
	assign out_neg   = neg_s7;

endmodule

`default_nettype wire

### hdl/spi_div.sv
// ---------------------------------------------------------------------------
// Segment/plane intersection: pipelined divider
// Restoring division, one quotient bit per stage, with a tag riding along.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_div
	import spi_pkg::*;
#(
	parameter int TAG_BITS = TAG_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_W-1:0]    in_num,
	input  logic [MAG_W-1:0]    in_den,
	input  logic [TAG_BITS-1:0] in_tag,
	output logic                out_valid,
	output logic [QUO_W-1:0]    out_quo,
	output logic [MAG_W-1:0]    out_rem,
	output logic [MAG_W-1:0]    out_den,
	output logic [TAG_BITS-1:0] out_tag
);

	logic                vld_s [0:QUO_W];
	logic [REM_W-1:0]    rem_s [0:QUO_W];
	logic [QUO_W-1:0]    low_s [0:QUO_W];
	logic [QUO_W-1:0]    quo_s [0:QUO_W];
	logic [MAG_W-1:0]    den_s [0:QUO_W];
	logic [TAG_BITS-1:0] tag_s [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= REM_W'(in_num[NUM_W-1:QUO_W]);
			low_s[0] <= in_num[QUO_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= in_den;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			trial = {rem_s[k][REM_W-2:0], low_s[k][QUO_W-1]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? trial - {1'b0, den_s[k]} : trial;
				low_s[k+1] <= low_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_rem   = rem_s[QUO_W][MAG_W-1:0];
	assign out_den   = den_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

`default_nettype wire

### hdl/segment_plane_intersect_top.sv
// ---------------------------------------------------------------------------
// Segment/plane intersection: top level
// Classifies a 3D segment against a plane and returns the crossing point.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one test per item: plane point, plane normal, segment
//   start and segment end, all signed Q16.16. m_axis returns one result per
//   item: the relation in tuser and the hit point in tdata (zero when the
//   segment misses or lies in the plane).
//   cfg writes dot_tolerance (index 0) and param_tolerance (index 1); other
//   indexes are dropped. cfg_ready is always high. Write only while idle.
//   Three stages form the dot products and four classify; the divider then
//   resolves one quotient bit per stage over 35 stages after its input
//   register, and a rounding register feeds the output buffer.
//   Throughput: one item per cycle while m_axis drains.
//   Reset clears the pipeline valid bits, the output buffer count and
//   pointers, and both tolerance registers to zero.
//   On a receiver stall results collect in a two-entry output buffer; once
//   it is full the whole pipeline holds and s_axis_tready drops, so no item
//   is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "segment_plane_intersect_top_defines.svh"

module segment_plane_intersect_top
	import spi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// fields from bit 0 up: plane_px, plane_py, plane_pz, normal_x, normal_y,
	// normal_z, start_x, start_y, start_z, end_x, end_y, end_z
	input  logic [12*COORD_W-1:0] s_axis_tdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// fields from bit 0 up: hit_x, hit_y, hit_z
	output logic [3*COORD_W-1:0]  m_axis_tdata,
	// fields from bit 0 up: relation
	output logic [1:0]            m_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BUF_W = 3 * COORD_W + 2;

	// configuration registers
	logic [DTOL_W-1:0] dot_tol_q;
	logic [PTOL_W-1:0] param_tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_tol_q   <= '0;
			param_tol_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DOT_TOL:   dot_tol_q   <= cfg_data[DTOL_W-1:0];
				REG_PARAM_TOL: param_tol_q <= cfg_data[PTOL_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline enable: advance whenever the output buffer has room
	logic [1:0] cnt_q;
	logic       en;

	assign en            = (cnt_q != 2'd2);
	assign s_axis_tready = en;

	// unpack the input item
	vec3_t in_pt, in_nrm, in_sa, in_sb;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pt[i]  = s_axis_tdata[(0 + i) * COORD_W +: COORD_W];
			in_nrm[i] = s_axis_tdata[(3 + i) * COORD_W +: COORD_W];
			in_sa[i]  = s_axis_tdata[(6 + i) * COORD_W +: COORD_W];
			in_sb[i]  = s_axis_tdata[(9 + i) * COORD_W +: COORD_W];
		end
	end

	// dot products
	logic                    dot_vld;
	logic signed [DOT_W-1:0] dot_num, dot_den;
	vec3_t                   dot_sa;
	dvec3_t                  dot_sd;

	spi_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_pt     (in_pt),
		.in_nrm    (in_nrm),
		.in_sa     (in_sa),
		.in_sb     (in_sb),
		.out_valid (dot_vld),
		.out_num   (dot_num),
		.out_den   (dot_den),
		.out_sa    (dot_sa),
		.out_sd    (dot_sd)
	);

	// classification and dividends
	logic             prep_vld;
	logic [1:0]       prep_rel;
	nvec3_t           prep_dvd;
	logic [MAG_W-1:0] prep_den;
	vec3_t            prep_sa;
	logic [2:0]       prep_neg;

	spi_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.dot_tol   (dot_tol_q),
		.param_tol (param_tol_q),
		.in_valid  (dot_vld),
		.in_num    (dot_num),
		.in_den    (dot_den),
		.in_sa     (dot_sa),
		.in_sd     (dot_sd),
		.out_valid (prep_vld),
		.out_rel   (prep_rel),
		.out_dvd   (prep_dvd),
		.out_den   (prep_den),
		.out_sa    (prep_sa),
		.out_neg   (prep_neg)
	);

	// one divider per coordinate; the x lane also carries the relation
	logic [2:0]       div_vld;
	logic [QUO_W-1:0] div_quo [3];
	logic [MAG_W-1:0] div_rem [3];
	logic [MAG_W-1:0] div_den [3];
	logic [TAG_W-1:0] div_tag [3];
	logic [1:0]       div_rel;

	spi_div #(
		.TAG_BITS (TAG_W + 2)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_vld),
		.in_num    (prep_dvd[0]),
		.in_den    (prep_den),
		.in_tag    ({prep_rel, prep_neg[0], prep_sa[0]}),
		.out_valid (div_vld[0]),
		.out_quo   (div_quo[0]),
		.out_rem   (div_rem[0]),
		.out_den   (div_den[0]),
		.out_tag   ({div_rel, div_tag[0]})
	);

	spi_div #(
		.TAG_BITS (TAG_W)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_vld),
		.in_num    (prep_dvd[1]),
		.in_den    (prep_den),
		.in_tag    ({prep_neg[1], prep_sa[1]}),
		.out_valid (div_vld[1]),
		.out_quo   (div_quo[1]),
		.out_rem   (div_rem[1]),
		.out_den   (div_den[1]),
		.out_tag   (div_tag[1])
	);

	spi_div #(
		.TAG_BITS (TAG_W)
	) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_vld),
		.in_num    (prep_dvd[2]),
		.in_den    (prep_den),
		.in_tag    ({prep_neg[2], prep_sa[2]}),
		.out_valid (div_vld[2]),
		.out_quo   (div_quo[2]),
		.out_rem   (div_rem[2]),
		.out_den   (div_den[2]),
		.out_tag   (div_tag[2])
	);

	// round to nearest, ties away from zero: bump when 2*rem >= den
	logic             vld_s8;
	logic [1:0]       rel_s8;
	logic [QUO_W-1:0] qr_s8 [3];
	logic [TAG_W-1:0] tag_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= div_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				qr_s8[i]  <= div_quo[i] + QUO_W'({div_rem[i], 1'b0} >= {1'b0, div_den[i]});
				tag_s8[i] <= div_tag[i];
			end
			rel_s8 <= div_rel;
		end
	end

	// add the signed offset to the start point and saturate
	logic signed [SUM_W-1:0] sum_c [3];
	logic signed [SUM_W-1:0] off_c [3];
	logic [3*COORD_W-1:0]    hit_c;
	logic                    has_pt;

	always_comb begin
		has_pt = (rel_s8 == REL_HIT) || (rel_s8 == REL_TOUCH);
		for (int i = 0; i < 3; i++) begin
			off_c[i] = $signed({2'b00, qr_s8[i]});
			if (tag_s8[i][COORD_W]) begin
				off_c[i] = -off_c[i];
			end
			sum_c[i] = SUM_W'($signed(tag_s8[i][COORD_W-1:0])) + off_c[i];
			priority if (!has_pt) begin
				hit_c[i*COORD_W +: COORD_W] = '0;
			end else if (sum_c[i] > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
				hit_c[i*COORD_W +: COORD_W] = {1'b0, {(COORD_W-1){1'b1}}};
			end else if (sum_c[i] < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}}))) begin
				hit_c[i*COORD_W +: COORD_W] = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				hit_c[i*COORD_W +: COORD_W] = sum_c[i][COORD_W-1:0];
			end
		end
	end

	// two-entry output buffer decouples the pipeline from the receiver
	logic [BUF_W-1:0] buf_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic             push, pop;

	assign push = en && vld_s8;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= {rel_s8, hit_c};
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = buf_q[rd_ptr_q][3*COORD_W-1:0];
	assign m_axis_tuser  = buf_q[rd_ptr_q][BUF_W-1:3*COORD_W];

	// checks
	`SPI_ASSERT_NEVER(a_buf_overflow, cnt_q == 2'd3, "output buffer count out of range")
	`SPI_ASSERT_NEVER(a_push_when_full, (cnt_q == 2'd2) && push, "push into full output buffer")
	`SPI_ASSERT_IMPLY(a_zero_point,
		m_axis_tvalid && (m_axis_tuser == REL_NONE || m_axis_tuser == REL_CONT),
		m_axis_tdata == '0, "point reported for a miss or a contained segment")
	`SPI_ASSERT_IMPLY(a_lanes_aligned, div_vld[0], div_vld[1] && div_vld[2],
		"divider lanes out of step")

endmodule

`default_nettype wire
